@@ rtl/utp_pkg.sv @@
// Shared types, character constants and the byte classifier for the UTF-8 preview filter.
// No dependencies; every other file of the block but utp_fifo refers to it by scoped names.
package utp_pkg;

  localparam int unsigned CNT_W = 17;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [20:0] CP_MIN2 = 21'h00080;
  localparam logic [20:0] CP_MIN3 = 21'h00800;
  localparam logic [20:0] CP_MIN4 = 21'h10000;
  localparam logic [20:0] CP_MAX  = 21'h10FFFF;
  localparam logic [20:0] SURR_LO = 21'h0D800;
  localparam logic [20:0] SURR_HI = 21'h0DFFF;

  localparam logic [CNT_W-1:0] CAP_RESET = 17'd128;

  typedef enum logic [2:0] {
    CLS_CTRL,
    CLS_WS,
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_STRAY
  } byte_class_e;

  // One input byte as it waits in the front queue.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    byte_class_e cls;
  } item_t;

  // One byte waiting for examination inside the back engine.
  typedef struct packed {
    logic [7:0]  data;
    byte_class_e cls;
  } work_t;

  // One result on its way to the output queue.
  typedef struct packed {
    logic [7:0] data;
    logic       done;
  } result_t;

  function automatic byte_class_e classify(input logic [7:0] b);
    byte_class_e cls;
    if (b == CHAR_TAB || b == CHAR_LF || b == CHAR_CR || b == CHAR_SPACE) begin
      cls = CLS_WS;
    end else if (b < CHAR_SPACE || b == CHAR_DEL) begin
      cls = CLS_CTRL;
    end else if (b[7] == 1'b0) begin
      cls = CLS_ASCII;
    end else if (b[7:5] == 3'b110) begin
      cls = CLS_LEAD2;
    end else if (b[7:4] == 4'b1110) begin
      cls = CLS_LEAD3;
    end else if (b[7:3] == 5'b11110) begin
      cls = CLS_LEAD4;
    end else begin
      cls = CLS_STRAY;
    end
    return cls;
  endfunction

endpackage

@@ rtl/utp_fifo.sv @@
// Small flop-based first-in first-out queue of generic width and depth.
// No dependencies on the package.
module utp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/utp_front.sv @@
// Front end: accepts input bytes, classifies them and queues them for the back engine.
// Depends on utp_pkg and utp_fifo.
module utp_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_byte_i,
  input  logic           in_last_i,
  output logic           item_valid_o,
  output utp_pkg::item_t item_o,
  input  logic           item_pop_i
);

  utp_pkg::item_t                     wr_item;
  logic [$bits(utp_pkg::item_t)-1:0]  rd_vec;
  logic                               full, empty;

  // Classify on entry so the engine sees the byte kind straight from the queue.
  always_comb begin
    wr_item.data = in_byte_i;
    wr_item.last = in_last_i;
    wr_item.cls  = utp_pkg::classify(in_byte_i);
  end

  utp_fifo #(
    .WIDTH ($bits(utp_pkg::item_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .data_i  (wr_item),
    .full_o  (full),
    .pop_i   (item_pop_i),
    .data_o  (rd_vec),
    .empty_o (empty)
  );

  assign in_ready_o   = !full;
  assign item_valid_o = !empty;
  assign item_o       = utp_pkg::item_t'(rd_vec);

endmodule

@@ rtl/utp_back.sv @@
// Back engine: examines one byte and issues at most one result per cycle, holding while
// res_ready_i is low. Depends on utp_pkg; fed by utp_front, drains into the output queue.
module utp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [utp_pkg::CNT_W-1:0]   budget_i,
  input  logic                        item_valid_i,
  input  utp_pkg::item_t              item_i,
  output logic                        item_pop_o,
  input  logic                        res_ready_i,
  output logic                        res_valid_o,
  output utp_pkg::result_t            res_o
);

  localparam int unsigned CW = utp_pkg::CNT_W;

  logic [CW-1:0]   emitted_q, emitted_d;
  logic            after_space_q, after_space_d;
  logic [7:0]      held_q [3];
  logic [7:0]      held_d [3];
  logic [2:0]      seq_len_q, seq_len_d;
  logic [1:0]      held_cnt_q, held_cnt_d;
  logic            finished_q, finished_d;
  logic            close_pend_q, close_pend_d;
  logic [7:0]      burst_q [3];
  logic [7:0]      burst_d [3];
  logic [1:0]      burst_n_q, burst_n_d;
  logic            active_q, active_d;
  logic            eod_q, eod_d;
  utp_pkg::work_t  wq_q [3];
  utp_pkg::work_t  wq_d [3];
  logic [1:0]      wn_q, wn_d;

  logic            retire, clear_item, pop, load;
  logic [7:0]      c;
  logic [CW-1:0]   emitted_inc;
  logic            inc_hits, ge_budget;
  logic [2:0]      len_new;
  logic            fits_new, fits_seq;
  logic [7:0]      s1, s2;
  logic            cont_ok, range_ok, seq_ok;
  logic [20:0]     cp;
  utp_pkg::work_t  h1_w, h2_w;

  assign c           = wq_q[0].data;
  assign emitted_inc = emitted_q + 1'b1;
  assign inc_hits    = ({1'b0, emitted_q} + 18'd1) >= {1'b0, budget_i};
  assign ge_budget   = emitted_q >= budget_i;

  always_comb begin
    case (wq_q[0].cls)
      utp_pkg::CLS_LEAD3: len_new = 3'd3;
      utp_pkg::CLS_LEAD4: len_new = 3'd4;
      default:            len_new = 3'd2;
    endcase
  end

  assign fits_new = ({1'b0, emitted_q} + 18'(len_new)) <= {1'b0, budget_i};
  assign fits_seq = ({1'b0, emitted_q} + 18'(seq_len_q)) <= {1'b0, budget_i};

  // Assemble the completed sequence: the current byte takes the place after the held ones.
  assign s1 = (seq_len_q == 3'd2) ? c : held_q[1];
  assign s2 = (seq_len_q == 3'd3) ? c : held_q[2];

  always_comb begin
    unique case (seq_len_q)
      3'd2: begin
        cont_ok  = (s1[7:6] == 2'b10);
        cp       = {10'd0, held_q[0][4:0], s1[5:0]};
        range_ok = cp >= utp_pkg::CP_MIN2;
      end
      3'd3: begin
        cont_ok  = (s1[7:6] == 2'b10) && (s2[7:6] == 2'b10);
        cp       = {5'd0, held_q[0][3:0], s1[5:0], s2[5:0]};
        range_ok = (cp >= utp_pkg::CP_MIN3) &&
                   !((cp >= utp_pkg::SURR_LO) && (cp <= utp_pkg::SURR_HI));
      end
      3'd4: begin
        cont_ok  = (s1[7:6] == 2'b10) && (s2[7:6] == 2'b10) && (c[7:6] == 2'b10);
        cp       = {held_q[0][2:0], s1[5:0], s2[5:0], c[5:0]};
        range_ok = (cp >= utp_pkg::CP_MIN4) && (cp <= utp_pkg::CP_MAX);
      end
      default: begin
        cont_ok  = 1'b0;
        cp       = '0;
        range_ok = 1'b0;
      end
    endcase
  end

  assign seq_ok = cont_ok && range_ok;

  always_comb begin
    h1_w.data = held_q[1];
    h1_w.cls  = utp_pkg::classify(held_q[1]);
    h2_w.data = held_q[2];
    h2_w.cls  = utp_pkg::classify(held_q[2]);
  end

  always_comb begin
    emitted_d     = emitted_q;
    after_space_d = after_space_q;
    held_d        = held_q;
    seq_len_d     = seq_len_q;
    held_cnt_d    = held_cnt_q;
    finished_d    = finished_q;
    close_pend_d  = close_pend_q;
    burst_d       = burst_q;
    burst_n_d     = burst_n_q;
    active_d      = active_q;
    eod_d         = eod_q;
    wq_d          = wq_q;
    wn_d          = wn_q;
    retire        = 1'b0;
    clear_item    = 1'b0;
    pop           = 1'b0;
    res_valid_o   = 1'b0;
    res_o.data    = utp_pkg::CHAR_NUL;
    res_o.done    = 1'b0;

    if (res_ready_i && active_q) begin
      if (close_pend_q) begin
        // terminator, then drop whatever is left of this item
        res_valid_o = 1'b1;
        res_o.done  = 1'b1;
        finished_d  = 1'b1;
        close_pend_d = 1'b0;
        retire      = 1'b1;
        clear_item  = eod_q;
      end else if (burst_n_q != 2'd0) begin
        res_valid_o  = 1'b1;
        res_o.data   = burst_q[0];
        emitted_d    = emitted_inc;
        close_pend_d = inc_hits;
        burst_d[0]   = burst_q[1];
        burst_d[1]   = burst_q[2];
        burst_n_d    = burst_n_q - 2'd1;
        if (burst_n_q == 2'd1 && !inc_hits && wn_q == 2'd0 && !eod_q) begin
          retire = 1'b1;
        end
      end else if (finished_q) begin
        retire     = 1'b1;
        clear_item = eod_q;
      end else if (wn_q != 2'd0) begin
        if (ge_budget) begin
          res_valid_o = 1'b1;
          res_o.done  = 1'b1;
          finished_d  = 1'b1;
          retire      = 1'b1;
          clear_item  = eod_q;
        end else if (seq_len_q != 3'd0) begin
          if (({1'b0, held_cnt_q} + 3'd1) < seq_len_q) begin
            held_d[held_cnt_q] = c;
            held_cnt_d         = held_cnt_q + 2'd1;
            pop                = 1'b1;
          end else begin
            seq_len_d     = 3'd0;
            held_cnt_d    = 2'd0;
            after_space_d = 1'b0;
            res_valid_o   = 1'b1;
            emitted_d     = emitted_inc;
            if (seq_ok && !fits_seq) begin
              res_o.data   = utp_pkg::CHAR_QMARK;
              close_pend_d = 1'b1;
              pop          = 1'b1;
            end else if (seq_ok) begin
              // lead goes out now, the rest follows from the burst register
              res_o.data   = held_q[0];
              close_pend_d = inc_hits;
              burst_d[0]   = s1;
              burst_d[1]   = s2;
              burst_d[2]   = c;
              burst_n_d    = 2'(seq_len_q - 3'd1);
              pop          = 1'b1;
            end else begin
              // replace the lead, then examine the bytes after it again
              res_o.data   = utp_pkg::CHAR_QMARK;
              close_pend_d = inc_hits;
              if (!inc_hits) begin
                case (seq_len_q)
                  3'd3: begin
                    wq_d[0] = h1_w;
                    wq_d[1] = wq_q[0];
                    wq_d[2] = wq_q[1];
                    wn_d    = wn_q + 2'd1;
                  end
                  3'd4: begin
                    wq_d[0] = h1_w;
                    wq_d[1] = h2_w;
                    wq_d[2] = wq_q[0];
                    wn_d    = wn_q + 2'd2;
                  end
                  default: begin
                  end
                endcase
              end
            end
          end
        end else begin
          pop = 1'b1;
          case (wq_q[0].cls)
            utp_pkg::CLS_WS: begin
              if (!after_space_q) begin
                after_space_d = 1'b1;
                res_valid_o   = 1'b1;
                res_o.data    = utp_pkg::CHAR_SPACE;
                emitted_d     = emitted_inc;
                close_pend_d  = inc_hits;
              end
            end
            utp_pkg::CLS_CTRL: begin
            end
            utp_pkg::CLS_ASCII: begin
              after_space_d = 1'b0;
              res_valid_o   = 1'b1;
              res_o.data    = c;
              emitted_d     = emitted_inc;
              close_pend_d  = inc_hits;
            end
            utp_pkg::CLS_LEAD2, utp_pkg::CLS_LEAD3, utp_pkg::CLS_LEAD4: begin
              if (!fits_new) begin
                res_valid_o  = 1'b1;
                res_o.data   = utp_pkg::CHAR_QMARK;
                emitted_d    = emitted_inc;
                close_pend_d = 1'b1;
              end else begin
                held_d[0]  = c;
                held_cnt_d = 2'd1;
                seq_len_d  = len_new;
              end
            end
            default: begin
              // stray byte: replace it, spacing state stays as it was
              res_valid_o  = 1'b1;
              res_o.data   = utp_pkg::CHAR_QMARK;
              emitted_d    = emitted_inc;
              close_pend_d = inc_hits;
            end
          endcase
        end
        if (pop) begin
          wq_d[0] = wq_q[1];
          wq_d[1] = wq_q[2];
          wn_d    = wn_q - 2'd1;
        end
        if (!close_pend_d && burst_n_d == 2'd0 && wn_d == 2'd0 && !eod_q) begin
          retire = 1'b1;
        end
      end else begin
        if (eod_q && seq_len_q != 3'd0) begin
          // sequence cut short by end of data
          res_valid_o  = 1'b1;
          res_o.data   = utp_pkg::CHAR_QMARK;
          emitted_d    = emitted_inc;
          seq_len_d    = 3'd0;
          close_pend_d = 1'b1;
        end else if (eod_q) begin
          res_valid_o = 1'b1;
          res_o.done  = 1'b1;
          retire      = 1'b1;
          clear_item  = 1'b1;
        end else begin
          retire = 1'b1;
        end
      end
    end

    if (clear_item) begin
      emitted_d     = '0;
      after_space_d = 1'b1;
      seq_len_d     = 3'd0;
      held_cnt_d    = 2'd0;
      finished_d    = 1'b0;
      close_pend_d  = 1'b0;
      burst_n_d     = 2'd0;
    end
    if (retire) begin
      active_d = 1'b0;
      wn_d     = 2'd0;
    end

    load = item_valid_i && (!active_q || retire);
    if (load) begin
      active_d     = 1'b1;
      eod_d        = item_i.last;
      wq_d[0].data = item_i.data;
      wq_d[0].cls  = item_i.cls;
      wn_d         = 2'd1;
    end
  end

  assign item_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emitted_q     <= '0;
      after_space_q <= 1'b1;
      seq_len_q     <= 3'd0;
      held_cnt_q    <= 2'd0;
      finished_q    <= 1'b0;
      close_pend_q  <= 1'b0;
      burst_n_q     <= 2'd0;
      active_q      <= 1'b0;
      eod_q         <= 1'b0;
      wn_q          <= 2'd0;
    end else begin
      emitted_q     <= emitted_d;
      after_space_q <= after_space_d;
      seq_len_q     <= seq_len_d;
      held_cnt_q    <= held_cnt_d;
      finished_q    <= finished_d;
      close_pend_q  <= close_pend_d;
      burst_n_q     <= burst_n_d;
      active_q      <= active_d;
      eod_q         <= eod_d;
      wn_q          <= wn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q  <= held_d;
    burst_q <= burst_d;
    wq_q    <= wq_d;
  end

endmodule

@@ rtl/utf8_text_preview_filter.sv @@
// Top level of the UTF-8 text preview filter: config register, front queue, engine, output queue.
// Depends on utp_pkg, utp_fifo, utp_front and utp_back.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-----------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tdata[7:0] in_byte, tlast end_of_data
//  m_axis   | out       | m_axis_tvalid/tready    | tdata[7:0] out_byte, tlast preview_done
//  cfg      | in        | cfg_we_i (no wait)      | cfg_wdata_i[16:0] preview_capacity
//
// Rate: the engine examines one byte and issues at most one result per cycle while the output
// queue has room, so printable ASCII, whitespace and control bytes run at one byte per cycle. A
// valid UTF-8 sequence is held until its last byte is collected, which issues the lead; the
// rest then issue from the burst register. A bad sequence has its lead replaced by a question
// mark and the bytes after the lead examined again. End of data closes an open preview.
// Reset: asynchronous, clears all control state at once; no clearing pass.
// Stalls: the output queue of OUT_DEPTH results absorbs bursts; when it is full the engine
// holds, and the front queue of FRONT_DEPTH bytes keeps accepting until it fills.
module utf8_text_preview_filter #(
  parameter int unsigned FRONT_DEPTH = 4,
  parameter int unsigned OUT_DEPTH   = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // s_axis_tdata: [7:0] in_byte
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,
  input  logic                      s_axis_tlast,
  // m_axis_tdata: [7:0] out_byte
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,
  output logic                      m_axis_tlast,
  input  logic                      cfg_we_i,
  input  logic [utp_pkg::CNT_W-1:0] cfg_wdata_i
);

  localparam int unsigned CW = utp_pkg::CNT_W;

  // Keep the text budget (capacity less the terminator) rather than the capacity itself.
  logic [CW-1:0]                        budget_q, budget_d;
  logic                                 item_valid, item_pop;
  utp_pkg::item_t                       item;
  logic                                 res_valid, out_full, out_empty;
  utp_pkg::result_t                     res;
  logic [$bits(utp_pkg::result_t)-1:0]  out_vec;
  utp_pkg::result_t                     out_res;

  always_comb begin
    budget_d = budget_q;
    if (cfg_we_i) begin
      // a capacity of zero acts as a capacity of one
      budget_d = (cfg_wdata_i == '0) ? '0 : cfg_wdata_i - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= utp_pkg::CAP_RESET - 1'b1;
    end else begin
      budget_q <= budget_d;
    end
  end

  // Accept and classify each transfer.
  utp_front #(
    .DEPTH (FRONT_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // Filter, validate and budget; advance only while the output queue has room.
  utp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .budget_i     (budget_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_ready_i  (!out_full),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Hold results until the downstream side takes them.
  utp_fifo #(
    .WIDTH ($bits(utp_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (out_full),
    .pop_i   (m_axis_tready),
    .data_o  (out_vec),
    .empty_o (out_empty)
  );

  assign out_res       = utp_pkg::result_t'(out_vec);
  assign m_axis_tvalid = !out_empty;
  assign m_axis_tdata  = out_res.data;
  assign m_axis_tlast  = out_res.done;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for utf8_text_preview_filter: directed and random byte streams, checked transfer by
// transfer against a behavioral predictor. Depends on utp_pkg and the RTL of the filter.
module testbench;

  localparam int unsigned MAX_RESULTS   = 6;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_BYTES  = 110;

  logic                      clk_i;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata  = 8'h00;
  logic                      s_axis_tlast  = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [7:0]                m_axis_tdata;
  logic                      m_axis_tlast;
  logic                      cfg_we_i      = 1'b0;
  logic [utp_pkg::CNT_W-1:0] cfg_wdata_i   = '0;

  utf8_text_preview_filter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Predictor state of the filter.
  logic [utp_pkg::CNT_W-1:0] cap_shadow;
  logic [utp_pkg::CNT_W-1:0] emitted;
  logic                      after_space;
  logic [7:0]                held [0:2];
  int unsigned               seq_len;
  int unsigned               held_cnt;
  logic                      preview_closed;
  int unsigned               step_results;

  utp_pkg::result_t expected_preview [$];
  logic [7:0]       text_q [$];

  int unsigned error_count;
  int unsigned bytes_sent;
  int unsigned results_seen;
  int unsigned previews_closed;
  int unsigned cap_writes;
  bit          idle_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned budget_now();
    return (cap_shadow == 0) ? 0 : int'(cap_shadow) - 1;
  endfunction

  function automatic void clear_preview();
    emitted        = '0;
    after_space    = 1'b1;
    held[0]        = 8'h00;
    held[1]        = 8'h00;
    held[2]        = 8'h00;
    seq_len        = 0;
    held_cnt       = 0;
    preview_closed = 1'b0;
  endfunction

  function automatic void emit_terminator();
    utp_pkg::result_t r;
    if (step_results < MAX_RESULTS) begin
      r.data = utp_pkg::CHAR_NUL;
      r.done = 1'b1;
      expected_preview.push_back(r);
      step_results++;
    end
    preview_closed = 1'b1;
  endfunction

  function automatic void emit_text(input logic [7:0] b);
    utp_pkg::result_t r;
    if (step_results < MAX_RESULTS) begin
      r.data = b;
      r.done = 1'b0;
      expected_preview.push_back(r);
      step_results++;
    end
    emitted = emitted + 1'b1;
    if (emitted >= budget_now()) emit_terminator();
  endfunction

  function automatic void predict_byte(input logic [7:0] in_byte, input logic end_of_data);
    logic [7:0]  pend [0:7];
    logic [7:0]  redo [0:7];
    logic [7:0]  seqb [0:3];
    logic [7:0]  c;
    int unsigned pend_n, pend_i, len, m, k, cp;
    bit          ok;
    step_results = 0;
    pend[0] = in_byte;
    pend_n  = 1;
    pend_i  = 0;
    if (!preview_closed && emitted >= budget_now()) emit_terminator();
    while (pend_i < pend_n && !preview_closed) begin
      c = pend[pend_i];
      pend_i++;
      if (seq_len != 0) begin
        len = seq_len;
        if (held_cnt + 1 < len && held_cnt < 3) begin
          held[held_cnt] = c;
          held_cnt++;
        end else begin
          for (k = 0; k < held_cnt; k++) seqb[k] = held[k];
          seqb[held_cnt] = c;
          seq_len  = 0;
          held_cnt = 0;
          cp = (len == 2) ? seqb[0][4:0] : (len == 3) ? seqb[0][3:0] : seqb[0][2:0];
          ok = 1'b1;
          for (k = 1; k < len; k++) begin
            if (ok) begin
              if (seqb[k][7:6] != 2'b10) ok = 1'b0;
              else cp = (cp << 6) | seqb[k][5:0];
            end
          end
          // The masked lead bounds the top of the 2- and 3-byte ranges already.
          if (len == 2)      ok = ok && (cp >= utp_pkg::CP_MIN2);
          else if (len == 3) ok = ok && (cp >= utp_pkg::CP_MIN3);
          else ok = ok && (cp >= utp_pkg::CP_MIN4) && (cp <= utp_pkg::CP_MAX);
          if (cp >= utp_pkg::SURR_LO && cp <= utp_pkg::SURR_HI) ok = 1'b0;
          after_space = 1'b0;
          if (ok) begin
            if (emitted + len > budget_now()) begin
              emit_text(utp_pkg::CHAR_QMARK);
              if (!preview_closed) emit_terminator();
            end else begin
              for (k = 0; k < len; k++) emit_text(seqb[k]);
            end
          end else begin
            emit_text(utp_pkg::CHAR_QMARK);
            // Re-examine the bytes after the lead, then whatever is still pending.
            m = 0;
            for (k = 1; k < len; k++) begin
              redo[m] = seqb[k];
              m++;
            end
            while (pend_i < pend_n && m < 8) begin
              redo[m] = pend[pend_i];
              m++;
              pend_i++;
            end
            pend   = redo;
            pend_n = m;
            pend_i = 0;
          end
        end
      end else if (c <= utp_pkg::CHAR_SPACE || c == utp_pkg::CHAR_DEL) begin
        if ((c == utp_pkg::CHAR_TAB || c == utp_pkg::CHAR_LF || c == utp_pkg::CHAR_CR ||
             c == utp_pkg::CHAR_SPACE) && !after_space) begin
          after_space = 1'b1;
          emit_text(utp_pkg::CHAR_SPACE);
        end
      end else if (c[7] == 1'b0) begin
        after_space = 1'b0;
        emit_text(c);
      end else begin
        if (c[7:5] == 3'b110)        len = 2;
        else if (c[7:4] == 4'b1110)  len = 3;
        else if (c[7:3] == 5'b11110) len = 4;
        else                         len = 0;
        if (len == 0) begin
          emit_text(utp_pkg::CHAR_QMARK);
        end else if (emitted + len > budget_now()) begin
          emit_text(utp_pkg::CHAR_QMARK);
          if (!preview_closed) emit_terminator();
        end else begin
          held[0]  = c;
          held_cnt = 1;
          seq_len  = len;
        end
      end
    end
    if (end_of_data) begin
      if (!preview_closed) begin
        if (seq_len != 0) emit_text(utp_pkg::CHAR_QMARK);
        if (!preview_closed) emit_terminator();
      end
      clear_preview();
    end
  endfunction

  // ---------------------------------------------------------------- monitor and checker

  always @(posedge clk_i) begin
    utp_pkg::result_t exp_r;
    if (rst_ni) begin
      if (cfg_we_i) cap_shadow = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_preview.size() == 0) begin
          $error("unexpected result: out_byte %02h preview_done %0b", m_axis_tdata, m_axis_tlast);
          error_count++;
        end else begin
          exp_r = expected_preview.pop_front();
          if (m_axis_tdata !== exp_r.data) begin
            $error("out_byte mismatch: expected %02h, actual %02h", exp_r.data, m_axis_tdata);
            error_count++;
          end
          if (m_axis_tlast !== exp_r.done) begin
            $error("preview_done mismatch: expected %0b, actual %0b", exp_r.done, m_axis_tlast);
            error_count++;
          end
          if (exp_r.done) previews_closed++;
        end
      end
    end
  end

  // Receiver: stall in random bursts while idling is on.
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  task automatic send_byte(input logic [7:0] b, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Send the queued text; flag the last byte as end of data when asked.
  task automatic send_text(input bit close_item);
    int unsigned i;
    for (i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], close_item && (i == text_q.size() - 1));
    text_q.delete();
  endtask

  // Hold off until every expected transfer is back and the engine has gone quiet.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_preview.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [utp_pkg::CNT_W-1:0] value);
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    cap_writes++;
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  function automatic void add_code_point(input logic [20:0] cp);
    if (cp < utp_pkg::CP_MIN3) begin
      text_q.push_back({3'b110, cp[10:6]});
    end else if (cp < utp_pkg::CP_MIN4) begin
      text_q.push_back({4'b1110, cp[15:12]});
      text_q.push_back({2'b10, cp[11:6]});
    end else begin
      text_q.push_back({5'b11110, cp[20:18]});
      text_q.push_back({2'b10, cp[17:12]});
      text_q.push_back({2'b10, cp[11:6]});
    end
    text_q.push_back({2'b10, cp[5:0]});
  endfunction

  // Append a lead byte with fewer continuation bytes than it needs.
  function automatic void add_partial_lead();
    int unsigned need, k;
    case ($urandom_range(0, 2))
      0: begin text_q.push_back(8'($urandom_range(8'hC2, 8'hDF))); need = 1; end
      1: begin text_q.push_back(8'($urandom_range(8'hE1, 8'hEC))); need = 2; end
      default: begin text_q.push_back(8'($urandom_range(8'hF1, 8'hF3))); need = 3; end
    endcase
    for (k = $urandom_range(0, need - 1); k > 0; k--) text_q.push_back(cont_byte());
  endfunction

  function automatic void add_token();
    int unsigned pick, cp;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      text_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
    end else if (pick < 45) begin
      case ($urandom_range(0, 3))
        0:       text_q.push_back(utp_pkg::CHAR_TAB);
        1:       text_q.push_back(utp_pkg::CHAR_LF);
        2:       text_q.push_back(utp_pkg::CHAR_CR);
        default: text_q.push_back(utp_pkg::CHAR_SPACE);
      endcase
    end else if (pick < 50) begin
      if ($urandom_range(0, 4) == 0) text_q.push_back(utp_pkg::CHAR_DEL);
      else text_q.push_back(8'($urandom_range(8'h00, 8'h1F)));
    end else if (pick < 60) begin
      add_code_point(21'($urandom_range(32'h80, 32'h7FF)));
    end else if (pick < 70) begin
      cp = $urandom_range(32'h800, 32'hF7FF);
      if (cp >= utp_pkg::SURR_LO) cp += 32'h800;
      add_code_point(21'(cp));
    end else if (pick < 80) begin
      add_code_point(21'($urandom_range(32'h10000, 32'h10FFFF)));
    end else if (pick < 85) begin
      // overlong forms
      case ($urandom_range(0, 2))
        0: text_q.push_back(8'($urandom_range(8'hC0, 8'hC1)));
        1: begin
          text_q.push_back(8'hE0);
          text_q.push_back(8'($urandom_range(8'h80, 8'h9F)));
        end
        default: begin
          text_q.push_back(8'hF0);
          text_q.push_back(8'($urandom_range(8'h80, 8'h8F)));
          text_q.push_back(cont_byte());
        end
      endcase
      text_q.push_back(cont_byte());
    end else if (pick < 88) begin
      text_q.push_back(8'hED);
      text_q.push_back(8'($urandom_range(8'hA0, 8'hBF)));
      text_q.push_back(cont_byte());
    end else if (pick < 90) begin
      if ($urandom_range(0, 1) == 0) begin
        text_q.push_back(8'hF4);
        text_q.push_back(8'($urandom_range(8'h90, 8'hBF)));
      end else begin
        text_q.push_back(8'($urandom_range(8'hF5, 8'hF7)));
        text_q.push_back(cont_byte());
      end
      text_q.push_back(cont_byte());
      text_q.push_back(cont_byte());
    end else if (pick < 95) begin
      // broken continuation
      add_partial_lead();
      if ($urandom_range(0, 1) == 0) text_q.push_back(8'($urandom_range(8'h00, 8'h7F)));
      else text_q.push_back(8'($urandom_range(8'hC0, 8'hFF)));
    end else begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_whitespace_and_ascii();
    // leading blanks, controls, blank collapse, stray bytes keeping the blank state
    text_q = '{8'h20, 8'h09, 8'h41, 8'h00, 8'h0A, 8'h0D, 8'h80, 8'h20, 8'h7F, 8'hFF, 8'h7E};
    send_text(1'b1);
  endtask

  task automatic test_good_sequences();
    text_q = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
    send_text(1'b0);
  endtask

  task automatic test_bad_sequences();
    // overlong, surrogate, above the last code point, broken, then cut short by end of data
    text_q = '{8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
               8'hE2, 8'h41, 8'hC3};
    send_text(1'b1);
  endtask

  task automatic test_budget_limits();
    write_capacity(17'd4);
    text_q = '{8'h61, 8'h62, 8'h63, 8'h64, 8'h65};
    send_text(1'b1);
    write_capacity(17'd5);
    text_q = '{8'h61, 8'h62, 8'hE2, 8'h78};
    send_text(1'b1);
    write_capacity(17'd1);
    text_q = '{8'h7A, 8'h7B};
    send_text(1'b1);
    write_capacity(17'd0);
    text_q = '{8'h7A};
    send_text(1'b1);
    write_capacity(17'h1FFFF);
    text_q = '{8'h41, 8'h20};
    send_text(1'b1);
  endtask

  task automatic test_capacity_change();
    // shrink while a sequence is half collected
    write_capacity(17'd10);
    text_q = '{8'h61, 8'hC3};
    send_text(1'b0);
    write_capacity(17'd3);
    text_q = '{8'hA9, 8'h62};
    send_text(1'b1);
    // shrink below what is already emitted
    write_capacity(17'd128);
    text_q = '{8'h61, 8'h62, 8'h63};
    send_text(1'b0);
    write_capacity(17'd3);
    text_q = '{8'h64};
    send_text(1'b1);
  endtask

  task automatic test_random_text();
    int unsigned start, ntok, k, split, pick;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (bytes_sent - start > RANDOM_BYTES * 3 / 4) idle_on = 1'b0;
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 5)       write_capacity(17'($urandom_range(1, 8)));
        else if (pick < 8)  write_capacity(17'($urandom_range(9, 40)));
        else if (pick == 8) write_capacity(17'd65536);
        else                write_capacity(17'd128);
      end
      ntok = $urandom_range(3, 12);
      for (k = 0; k < ntok; k++) add_token();
      if ($urandom_range(0, 3) == 0) add_partial_lead();
      if ($urandom_range(0, 4) == 0) begin
        // change the budget in the middle of the preview
        split = $urandom_range(1, text_q.size() - 1);
        for (k = 0; k < split; k++) send_byte(text_q[k], 1'b0);
        for (k = 0; k < split; k++) void'(text_q.pop_front());
        write_capacity(17'($urandom_range(1, 12)));
      end else if ($urandom_range(0, 5) == 0) begin
        send_text(1'b0);
        wait_quiet();
        ntok = $urandom_range(1, 4);
        for (k = 0; k < ntok; k++) add_token();
      end
      send_text(1'b1);
    end
  endtask

  initial begin
    cap_shadow = utp_pkg::CAP_RESET;
    clear_preview();
    idle_on = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_whitespace_and_ascii();
    test_good_sequences();
    test_bad_sequences();
    test_budget_limits();
    test_capacity_change();
    test_random_text();

    wait_quiet();
    $display("Sent %0d bytes, checked %0d results and %0d closed previews", bytes_sent,
             results_seen, previews_closed);
    $display("Used %0d buffer size writes, budget cut-offs and malformed UTF-8", cap_writes);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/utp_pkg.sv
rtl/utp_fifo.sv
rtl/utp_front.sv
rtl/utp_back.sv
rtl/utf8_text_preview_filter.sv
test/testbench.sv
